[hw/rtl/vtx_pkg.sv]
// Shared constants, types and helper functions of the vertex transform unit.
package vtx_pkg;

    localparam int COEF_WIDTH = 16;                         // signed Q4.12 coefficient
    localparam int VEC_WIDTH  = 32;                         // signed Q16.16 component
    localparam int COEF_FRAC  = COEF_WIDTH - 4;
    localparam int VEC_FRAC   = VEC_WIDTH / 2;
    localparam int NUM_ROWS   = 4;
    localparam int NUM_COLS   = 4;
    localparam int LANE_WIDTH = 16;                         // coefficient lane in a row register
    localparam int ROW_REG_W  = LANE_WIDTH * NUM_COLS;
    localparam int CFG_ADDR_W = $clog2(NUM_ROWS);
    localparam int PROD_WIDTH = COEF_WIDTH + VEC_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;             // four products plus rounding
    localparam int ROW_WIDTH  = SUM_WIDTH - COEF_FRAC;      // rounded row value
    localparam int NUM_WIDTH  = ROW_WIDTH + VEC_FRAC;       // dividend with rounding term
    localparam int HI_WIDTH   = NUM_WIDTH - VEC_WIDTH;      // dividend bits above the quotient
    localparam int DIV_STEPS  = VEC_WIDTH;                  // one quotient bit per stage

    localparam logic [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
    localparam logic [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};
    localparam logic [VEC_WIDTH-1:0] VEC_ONE =
        VEC_WIDTH'(1) << VEC_FRAC;

    // Operation codes
    localparam logic OP_VECTOR = 1'b0;
    localparam logic OP_POINT  = 1'b1;

    // Identity matrix after reset
    localparam logic [ROW_REG_W-1:0] ROW_ONE = ROW_REG_W'(1) << COEF_FRAC;

    typedef logic signed [VEC_WIDTH-1:0]  t_vec;
    typedef logic signed [ROW_WIDTH-1:0]  t_row_val;
    typedef logic signed [PROD_WIDTH-1:0] t_prod;

    // One lane of the restoring divider: partial remainder and
    // dividend bits that shift out while quotient bits shift in.
    typedef struct packed {
        logic [VEC_WIDTH-1:0] rem;
        logic [VEC_WIDTH-1:0] nq;
        logic                 neg;
        logic                 ovf;
    } t_div_lane;

    // Per-item control that travels with the divider lanes
    typedef struct packed {
        logic                 point;
        logic                 dz;
        logic [VEC_WIDTH-1:0] den;
        logic [VEC_WIDTH-1:0] w;
    } t_div_ctl;

    // Saturate a row value to the signed component range
    function automatic logic [VEC_WIDTH-1:0] sat_vec(input t_row_val v);
        logic signed [ROW_WIDTH-1:0] hi;
        logic signed [ROW_WIDTH-1:0] lo;
        hi = ROW_WIDTH'($signed(VEC_MAX));
        lo = ROW_WIDTH'($signed(VEC_MIN));
        if (v > hi) begin
            return VEC_MAX;
        end else if (v < lo) begin
            return VEC_MIN;
        end
        return v[VEC_WIDTH-1:0];
    endfunction

    // One restoring division step: brings in the next dividend bit
    function automatic t_div_lane div_step(input t_div_lane l, input logic [VEC_WIDTH-1:0] d);
        logic [VEC_WIDTH:0] part;
        logic [VEC_WIDTH:0] diff;
        t_div_lane          o;
        part = {l.rem, l.nq[VEC_WIDTH-1]};
        diff = part - {1'b0, d};
        o    = l;
        if (part >= {1'b0, d}) begin
            o.rem = diff[VEC_WIDTH-1:0];
            o.nq  = {l.nq[VEC_WIDTH-2:0], 1'b1};
        end else begin
            o.rem = part[VEC_WIDTH-1:0];
            o.nq  = {l.nq[VEC_WIDTH-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

[hw/rtl/vertex_transform_4x4_unit.sv]
// Vertex transform unit: 4x4 fixed-point matrix times vector with optional perspective divide.
// Takes one vertex per clock when the output side does not stall and returns one result per
// vertex, in order. Stage 1 forms the sixteen 16x32 products, stage 2 adds each row and rounds
// it, stage 3 saturates w and sets up the dividends, then a 32-stage restoring divider yields
// one quotient bit per stage for x, y and z in parallel, and a final register saturates and
// selects the result. The whole pipeline advances when the output register is empty or taken,
// so s_axis_tready follows m_axis_tready. The user must write matrix rows through the
// configuration port only while idle, which the unit does not enforce; reset loads identity.
module vertex_transform_4x4_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [63:0]  i_cfg_data,
    // input vertex stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // in_x[31:0], in_y[63:32], in_z[95:64], in_w[127:96]
    input  logic         s_axis_tuser,   // operation
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic         m_axis_tuser    // divide_by_zero
);

    localparam int VW = vtx_pkg::VEC_WIDTH;

    // Matrix row registers
    logic [vtx_pkg::ROW_REG_W-1:0] r_row [vtx_pkg::NUM_ROWS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < vtx_pkg::NUM_ROWS; r++) begin
                r_row[r] <= vtx_pkg::ROW_ONE << (r * vtx_pkg::LANE_WIDTH);
            end
        end else if (i_cfg_we) begin
            r_row[i_cfg_addr] <= i_cfg_data;
        end
    end

    // Pipeline advance: output register empty or being taken
    logic adv;
    logic r_out_vld;
    assign adv           = !r_out_vld || m_axis_tready;
    assign s_axis_tready = adv;

    // Stage 1: products
    logic         r_s1_vld;
    logic         r_s1_point;
    vtx_pkg::t_prod r_s1_prod [vtx_pkg::NUM_ROWS][vtx_pkg::NUM_COLS];
    vtx_pkg::t_vec  vec_in [vtx_pkg::NUM_COLS];

    always_comb begin
        for (int j = 0; j < vtx_pkg::NUM_COLS; j++) begin
            vec_in[j] = s_axis_tdata[j*VW +: VW];
        end
        if (s_axis_tuser == vtx_pkg::OP_POINT) begin
            vec_in[vtx_pkg::NUM_COLS-1] = vtx_pkg::VEC_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_point <= s_axis_tuser;
            for (int r = 0; r < vtx_pkg::NUM_ROWS; r++) begin
                for (int j = 0; j < vtx_pkg::NUM_COLS; j++) begin
                    r_s1_prod[r][j] <=
                        $signed(r_row[r][j*vtx_pkg::LANE_WIDTH +: vtx_pkg::COEF_WIDTH])
                        * vec_in[j];
                end
            end
        end
    end

    // Stage 2: row sums, round half up
    logic              r_s2_vld;
    logic              r_s2_point;
    vtx_pkg::t_row_val r_s2_row [vtx_pkg::NUM_ROWS];
    logic signed [vtx_pkg::SUM_WIDTH-1:0] row_sum [vtx_pkg::NUM_ROWS];

    always_comb begin
        for (int r = 0; r < vtx_pkg::NUM_ROWS; r++) begin
            row_sum[r] = (vtx_pkg::SUM_WIDTH)'(r_s1_prod[r][0])
                       + (vtx_pkg::SUM_WIDTH)'(r_s1_prod[r][1])
                       + (vtx_pkg::SUM_WIDTH)'(r_s1_prod[r][2])
                       + (vtx_pkg::SUM_WIDTH)'(r_s1_prod[r][3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_point <= r_s1_point;
            for (int r = 0; r < vtx_pkg::NUM_ROWS; r++) begin
                r_s2_row[r] <= vtx_pkg::ROW_WIDTH'(
                    (row_sum[r] + (vtx_pkg::SUM_WIDTH'(1) << (vtx_pkg::COEF_FRAC - 1)) - 1'sb0)
                    >>> vtx_pkg::COEF_FRAC);
            end
        end
    end

    // Stage 3 and divider stages
    logic               r_dvld [vtx_pkg::DIV_STEPS+1];
    vtx_pkg::t_div_ctl  r_dctl [vtx_pkg::DIV_STEPS+1];
    vtx_pkg::t_div_lane r_dln  [vtx_pkg::DIV_STEPS+1][3];
    logic [VW-1:0]      r_dsat [vtx_pkg::DIV_STEPS+1][3];

    vtx_pkg::t_div_ctl  n_dctl;
    vtx_pkg::t_div_lane n_dln [3];
    logic [VW-1:0]      n_dsat [3];
    logic [VW-1:0]      w_sat;
    logic [vtx_pkg::ROW_WIDTH-1:0] mag [3];
    logic [vtx_pkg::NUM_WIDTH-1:0] num [3];
    logic [vtx_pkg::HI_WIDTH-1:0]  num_hi [3];

    // Dividend setup: |row| * 2^16 + den/2, overflow when quotient needs more than 32 bits
    always_comb begin
        w_sat          = vtx_pkg::sat_vec(r_s2_row[3]);
        n_dctl.point   = r_s2_point;
        n_dctl.w       = w_sat;
        n_dctl.dz      = (r_s2_point == vtx_pkg::OP_POINT) && (w_sat == '0);
        n_dctl.den     = w_sat[VW-1] ? VW'(-w_sat) : w_sat;
        for (int i = 0; i < 3; i++) begin
            n_dsat[i]       = vtx_pkg::sat_vec(r_s2_row[i]);
            mag[i]          = r_s2_row[i][vtx_pkg::ROW_WIDTH-1]
                            ? vtx_pkg::ROW_WIDTH'(-r_s2_row[i])
                            : vtx_pkg::ROW_WIDTH'(r_s2_row[i]);
            num[i]          = {mag[i], {vtx_pkg::VEC_FRAC{1'b0}}}
                            + vtx_pkg::NUM_WIDTH'(n_dctl.den >> 1);
            num_hi[i]       = num[i][vtx_pkg::NUM_WIDTH-1:VW];
            n_dln[i].rem    = VW'(num_hi[i]);
            n_dln[i].nq     = num[i][VW-1:0];
            n_dln[i].neg    = r_s2_row[i][vtx_pkg::ROW_WIDTH-1] ^ w_sat[VW-1];
            n_dln[i].ovf    = VW'(num_hi[i]) >= n_dctl.den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= vtx_pkg::DIV_STEPS; k++) begin
                r_dvld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_dvld[0] <= r_s2_vld;
            for (int k = 0; k < vtx_pkg::DIV_STEPS; k++) begin
                r_dvld[k+1] <= r_dvld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dctl[0] <= n_dctl;
            for (int i = 0; i < 3; i++) begin
                r_dln[0][i]  <= n_dln[i];
                r_dsat[0][i] <= n_dsat[i];
            end
            for (int k = 0; k < vtx_pkg::DIV_STEPS; k++) begin
                r_dctl[k+1] <= r_dctl[k];
                for (int i = 0; i < 3; i++) begin
                    r_dln[k+1][i]  <= vtx_pkg::div_step(r_dln[k][i], r_dctl[k].den);
                    r_dsat[k+1][i] <= r_dsat[k][i];
                end
            end
        end
    end

    // Final selection and output register
    localparam int LAST = vtx_pkg::DIV_STEPS;
    logic [VW-1:0]  n_res [3];
    logic [127:0]   r_out_data;
    logic           r_out_dz;
    vtx_pkg::t_div_lane fl [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fl[i] = r_dln[LAST][i];
            priority if (r_dctl[LAST].point == vtx_pkg::OP_VECTOR) begin
                n_res[i] = r_dsat[LAST][i];
            end else if (r_dctl[LAST].dz) begin
                n_res[i] = '0;
            end else if (fl[i].ovf) begin
                n_res[i] = fl[i].neg ? vtx_pkg::VEC_MIN : vtx_pkg::VEC_MAX;
            end else if (fl[i].neg) begin
                n_res[i] = (fl[i].nq > vtx_pkg::VEC_MIN) ? vtx_pkg::VEC_MIN : VW'(-fl[i].nq);
            end else begin
                n_res[i] = (fl[i].nq > vtx_pkg::VEC_MAX) ? vtx_pkg::VEC_MAX : fl[i].nq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_dvld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {r_dctl[LAST].w, n_res[2], n_res[1], n_res[0]};
            r_out_dz   <= r_dctl[LAST].dz;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_dz;

`ifndef SYNTHESIS
    // A zero divisor forces x, y and z to zero
    a_dz_zero_xyz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[95:0] == '0))
        else $error("divide_by_zero result with nonzero x, y or z");

    // A zero divisor is reported as out_w of zero
    a_dz_zero_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[127:96] == '0))
        else $error("divide_by_zero result with nonzero w");

    // A transaction held at the output keeps the pipeline frozen
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(r_dvld[LAST]) && m_axis_tvalid)
        else $error("pipeline moved during output stall");
`endif

endmodule
